FILE: hdl/sahsd_pkg.sv
// ----------------------------------------------------------------------------
// sahsd_pkg
// Shared widths, constants, codes and types of the half-step ramp driver.
// ----------------------------------------------------------------------------
package sahsd_pkg;

  localparam int VELOCITY_BITS_DEF = 48;

  localparam int ACCEL_W     = 25;
  localparam int DT_W        = 16;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 24;
  localparam int SINCE_W     = 32;
  localparam int POS_W       = 32;
  localparam int COIL_W      = 4;
  localparam int HOLD_W      = 24;
  localparam int MIN_SPEED_W = 40;
  localparam int PERIOD_W    = 16;
  localparam int SCALE_W     = 27;
  localparam int SCALED_W    = PERIOD_W + SCALE_W;

  localparam int IN_TDATA_W  = CHAR_W + DT_W;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = MIN_SPEED_W;

  localparam logic [SCALE_W-1:0] SCALE_1E8 = 27'd100000000;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 24'hFFFFFF;

  localparam logic [HOLD_W-1:0]      HOLD_RESET      = 24'd100000;
  localparam logic [MIN_SPEED_W-1:0] MIN_SPEED_RESET = 40'd1000000;
  localparam logic [PERIOD_W-1:0]    PERIOD_RESET    = 16'd2500;

  localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_TIMEOUT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_SPEED    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD_UNIT  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] accel;
    logic                      loaded;
  } cmd_out_t;

  function automatic logic [COIL_W-1:0] coil_pattern(input logic [2:0] phase);
    logic [COIL_W-1:0] pat;
    unique case (phase)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

FILE: hdl/sahsd_mul.sv
// ----------------------------------------------------------------------------
// sahsd_mul
// Iterative shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module sahsd_mul
  import sahsd_pkg::*;
#(
  parameter int A_W = VELOCITY_BITS_DEF - 1,
  parameter int B_W = SINCE_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] product
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W);

  logic [P_W-1:0]   p_r, p_nxt;
  logic [A_W-1:0]   a_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [A_W:0]     sum;

  always_comb begin
    sum      = {1'b0, p_r[P_W-1:B_W]} + (p_r[0] ? {1'b0, a_r} : '0);
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      p_nxt   = {{A_W{1'b0}}, b};
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      p_nxt   = {sum, p_r[B_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(B_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (start) begin
      a_r <= a;
    end
  end

  assign done    = done_r;
  assign product = p_r;

endmodule

FILE: hdl/sahsd_cmd.sv
// ----------------------------------------------------------------------------
// sahsd_cmd
// Command character parser: signed decimal number ended by CR or LF.
// ----------------------------------------------------------------------------
module sahsd_cmd
  import sahsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              char_valid,
  input  logic [CHAR_W-1:0] char_code,
  output cmd_out_t          cmd
);

  localparam int WIDE_W = DIGIT_W + 4;

  logic [DIGIT_W-1:0]        digit_r, digit_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [ACCEL_W-1:0] accel_r, accel_nxt;
  logic [WIDE_W-1:0]         wide;
  logic [CHAR_W-1:0]         digit_val;
  logic                      is_term;

  always_comb begin
    digit_val = char_code - CHAR_ZERO;
    wide      = (WIDE_W'(digit_r) << 3) + (WIDE_W'(digit_r) << 1) + WIDE_W'(digit_val);
    is_term   = (char_code == CHAR_CR) || (char_code == CHAR_LF);
    digit_nxt = digit_r;
    neg_nxt   = neg_r;
    accel_nxt = accel_r;
    if (char_valid) begin
      priority if (char_code == CHAR_MINUS) begin
        neg_nxt = 1'b1;
      end else if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
        digit_nxt = (wide > WIDE_W'(DIGIT_MAX)) ? DIGIT_MAX : wide[DIGIT_W-1:0];
      end else if (is_term) begin
        accel_nxt = neg_r ? -$signed({1'b0, digit_r}) : $signed({1'b0, digit_r});
        digit_nxt = '0;
        neg_nxt   = 1'b0;
      end else begin
        neg_nxt = neg_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= '0;
      neg_r   <= 1'b0;
      accel_r <= '0;
    end else begin
      digit_r <= digit_nxt;
      neg_r   <= neg_nxt;
      accel_r <= accel_nxt;
    end
  end

  assign cmd.accel  = accel_r;
  assign cmd.loaded = char_valid && is_term;

endmodule

FILE: hdl/stepper_accel_half_step_driver.sv
// ----------------------------------------------------------------------------
// stepper_accel_half_step_driver
// Half-step stepper driver with acceleration ramp and hold timeout.
//
//   channel | dir | tdata (low bit up)                      | tuser
//   in_     | in  | char_code, elapsed_us                   | kind
//   out_    | out | coils, position, velocity, acceleration | step_taken, accel_loaded
//   cfg_    | in  | 0 hold_timeout_us, 1 min_speed, 2 step_period_unit (write only)
//
// a character item passes accept and commit; a tick passes accept, one multiply,
// one add, one speed check, the shift-add multiplier forming time x speed,
// one compare and one commit; a tick that fails the speed check skips the
// multiplier. reset is synchronous.
// a finished item waits in the output register; the next item is taken
// meanwhile and only its commit cycle stalls on out_tready.
// ----------------------------------------------------------------------------
module stepper_accel_half_step_driver
  import sahsd_pkg::*;
#(
  parameter int VELOCITY_BITS = VELOCITY_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_TDATA_W-1:0]         in_tdata,  // char_code, elapsed_us
  input  logic [IN_TUSER_W-1:0]         in_tuser,  // kind

  output logic                          out_tvalid,
  input  logic                          out_tready,
  // coils, position, velocity, acceleration
  output logic [((COIL_W + POS_W + VELOCITY_BITS + ACCEL_W + 7) / 8) * 8 - 1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0]        out_tuser, // step_taken, accel_loaded

  input  logic                          cfg_we,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int VB       = VELOCITY_BITS;
  localparam int MAG_W    = VB - 1;
  localparam int DELTA_W  = ACCEL_W + DT_W + 1;
  localparam int SUM_W    = ((VB > DELTA_W) ? VB : DELTA_W) + 1;
  localparam int CMP_W    = (MAG_W > MIN_SPEED_W) ? MAG_W : MIN_SPEED_W;
  localparam int PROD_W   = MAG_W + SINCE_W;
  localparam int OUT_BITS = COIL_W + POS_W + VB + ACCEL_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic signed [SUM_W-1:0] VMAX_S = {{(SUM_W-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] VMIN_S = -VMAX_S;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_VEL, S_CHK, S_ITER, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic                      kind_r, kind_nxt;
  logic [DT_W-1:0]           dt_r, dt_nxt;
  logic signed [DELTA_W-1:0] delta_r, delta_nxt;
  logic signed [VB-1:0]      vel_r, vel_nxt;
  logic [SINCE_W-1:0]        since_r, since_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic [COIL_W-1:0]         coil_r, coil_nxt;
  logic                      step_r, step_nxt;
  logic                      loaded_r, loaded_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]          out_data_r, out_data_nxt;
  logic [OUT_TUSER_W-1:0]    out_user_r, out_user_nxt;

  logic [HOLD_W-1:0]         hold_r;
  logic [MIN_SPEED_W-1:0]    min_speed_r;
  logic [PERIOD_W-1:0]       period_r;
  logic [SCALED_W-1:0]       scaled_r;

  cmd_out_t                  cmd;
  logic                      accept;
  logic                      mul_start;
  logic                      mul_done;
  logic [PROD_W-1:0]         mul_prod;

  logic signed [DELTA_W-1:0] delta_c;
  logic signed [SUM_W-1:0]   sum_c;
  logic [SINCE_W:0]          since_sum_c;
  logic signed [VB-1:0]      neg_c;
  logic [MAG_W-1:0]          mag_c;
  logic                      speed_ok_c;
  logic [COIL_W-1:0]         coil_c;
  logic [SINCE_W-1:0]        since_c;
  logic [POS_W-1:0]          pos_c;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  sahsd_cmd u_cmd (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (accept && in_tuser[0]),
    .char_code  (in_tdata[CHAR_W-1:0]),
    .cmd        (cmd)
  );

  sahsd_mul #(
    .A_W (MAG_W),
    .B_W (SINCE_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mag_c),
    .b       (since_r),
    .done    (mul_done),
    .product (mul_prod)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r      <= HOLD_RESET;
      min_speed_r <= MIN_SPEED_RESET;
      period_r    <= PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_HOLD_TIMEOUT: hold_r      <= cfg_wdata[HOLD_W-1:0];
        CFG_MIN_SPEED:    min_speed_r <= cfg_wdata[MIN_SPEED_W-1:0];
        CFG_PERIOD_UNIT:  period_r    <= cfg_wdata[PERIOD_W-1:0];
        default:          hold_r      <= hold_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    scaled_r <= SCALED_W'(period_r) * SCALED_W'(SCALE_1E8);
  end

  always_comb begin
    delta_c     = DELTA_W'($signed(cmd.accel)) * DELTA_W'($signed({1'b0, dt_r}));
    sum_c       = {{(SUM_W-VB){vel_r[VB-1]}}, vel_r}
                + {{(SUM_W-DELTA_W){delta_r[DELTA_W-1]}}, delta_r};
    since_sum_c = {1'b0, since_r} + (SINCE_W+1)'(dt_r);
    neg_c       = -vel_r;
    mag_c       = vel_r[VB-1] ? neg_c[MAG_W-1:0] : vel_r[MAG_W-1:0];
    speed_ok_c  = (mag_c != '0) && (CMP_W'(mag_c) > CMP_W'(min_speed_r));

    coil_c  = step_r ? coil_pattern(pos_r[2:0]) : coil_r;
    since_c = step_r ? '0 : since_r;
    if (!kind_r && (since_c > SINCE_W'(hold_r))) begin
      coil_c = '0;
    end
    pos_c = pos_r;
    if (step_r) begin
      pos_c = vel_r[VB-1] ? pos_r - 1'b1 : pos_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    dt_nxt        = dt_r;
    delta_nxt     = delta_r;
    vel_nxt       = vel_r;
    since_nxt     = since_r;
    pos_nxt       = pos_r;
    coil_nxt      = coil_r;
    step_nxt      = step_r;
    loaded_nxt    = loaded_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    mul_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt   = in_tuser[0];
          dt_nxt     = in_tdata[CHAR_W +: DT_W];
          loaded_nxt = cmd.loaded;
          step_nxt   = 1'b0;
          state_nxt  = in_tuser[0] ? S_OUT : S_MUL;
        end
      end
      S_MUL: begin
        delta_nxt = delta_c;
        state_nxt = S_VEL;
      end
      S_VEL: begin
        priority if (sum_c > VMAX_S) begin
          vel_nxt = VMAX_S[VB-1:0];
        end else if (sum_c < VMIN_S) begin
          vel_nxt = VMIN_S[VB-1:0];
        end else begin
          vel_nxt = sum_c[VB-1:0];
        end
        since_nxt = since_sum_c[SINCE_W] ? '1 : since_sum_c[SINCE_W-1:0];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (speed_ok_c) begin
          mul_start = 1'b1;
          state_nxt = S_ITER;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_ITER: begin
        if (mul_done) begin
          step_nxt  = mul_prod > PROD_W'(scaled_r);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          coil_nxt      = coil_c;
          since_nxt     = since_c;
          pos_nxt       = pos_c;
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({cmd.accel, vel_r, pos_c, coil_c});
          out_user_nxt  = {loaded_r, step_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vel_r       <= '0;
      since_r     <= '0;
      pos_r       <= '0;
      coil_r      <= '0;
      step_r      <= 1'b0;
      loaded_r    <= 1'b0;
      kind_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vel_r       <= vel_nxt;
      since_r     <= since_nxt;
      pos_r       <= pos_nxt;
      coil_r      <= coil_nxt;
      step_r      <= step_nxt;
      loaded_r    <= loaded_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dt_r       <= dt_nxt;
    delta_r    <= delta_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // a step always drives a nonzero coil pattern
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[COIL_W-1:0] != '0))
    else $error("step without coil drive");

  // an item never both steps and loads an acceleration
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("step and accel load in one item");

  // velocity stays inside the symmetric range
  assert property (@(posedge clk) disable iff (!rst_n)
    vel_r != {1'b1, {(VB-1){1'b0}}})
    else $error("velocity left symmetric range");

  // multiplier finishes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_ITER))
    else $error("multiplier done outside wait state");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the half-step ramp driver. Sends time ticks and command
// characters in bursts with random gaps while the result side stalls on its
// own pattern. Each result is predicted by a behavioral model of the driver
// or taken from a directed table row, and compared field by field. The run
// steps through several register settings, including both extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import sahsd_pkg::*;

  localparam int VEL_W       = VELOCITY_BITS_DEF;
  localparam int OUT_TDATA_W = ((COIL_W + POS_W + VEL_W + ACCEL_W + 7) / 8) * 8;
  localparam int POS_LSB     = COIL_W;
  localparam int VEL_LSB     = POS_LSB + POS_W;
  localparam int ACC_LSB     = VEL_LSB + VEL_W;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CHAR = 1'b1;

  localparam longint          VEL_MAX       = (longint'(1) << (VEL_W - 1)) - 1;
  localparam logic [31:0]     HALF_STEP_SEQ = 32'h98C4_6231;
  localparam longint unsigned TEN_POW_8     = 64'd100000000;

  localparam int PHASES          = 6;
  localparam int PHASE_ITEMS     = 45;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SAT_TICKS_UP    = 135;
  localparam int SAT_TICKS_DOWN  = 265;
  localparam int TAIL_CYCLES     = 100;

  typedef struct packed {
    logic [COIL_W-1:0]  coils;
    logic               step;
    logic [POS_W-1:0]   pos;
    logic [VEL_W-1:0]   vel;
    logic [ACCEL_W-1:0] acc;
    logic               loaded;
  } drive_result_t;

  typedef struct packed {
    logic               kind;
    logic [CHAR_W-1:0]  ch;
    logic [DT_W-1:0]    dt;
    logic               typed;
    logic [ACCEL_W-1:0] acc;
    logic               loaded;
  } dir_row_t;

  logic clk;
  logic rst_n;

  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // char_code, elapsed_us
  logic [IN_TUSER_W-1:0]  in_tuser;   // kind

  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // coils, position, velocity, acceleration
  logic [OUT_TUSER_W-1:0] out_tuser;  // step_taken, accel_loaded

  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // driver model state
  longint            m_vel;
  longint            m_accel;
  longint unsigned   m_digits;
  logic              m_neg;
  logic [POS_W-1:0]  m_pos;
  longint unsigned   m_since;
  logic [COIL_W-1:0] m_coils;
  longint unsigned   r_hold;
  longint unsigned   r_min;
  longint unsigned   r_period;

  drive_result_t result_q[$];
  dir_row_t      dir_tab[$];

  int err_cnt;
  int items_sent;
  int burst_left;
  bit hold_off_req;

  stepper_accel_half_step_driver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic drive_result_t advance_driver(input logic kind,
                                                   input logic [CHAR_W-1:0] ch,
                                                   input logic [DT_W-1:0] dt);
    drive_result_t   r;
    longint          delta;
    longint unsigned mag;
    longint unsigned t;
    logic [31:0]     seq;
    r = '0;
    if (kind == KIND_CHAR) begin
      if (ch == CHAR_MINUS) begin
        m_neg = 1'b1;
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
        t = m_digits * 10 + 64'(ch - CHAR_ZERO);
        if (t > 64'(DIGIT_MAX)) t = 64'(DIGIT_MAX);
        m_digits = t;
      end else if (ch == CHAR_CR || ch == CHAR_LF) begin
        m_accel  = m_neg ? -longint'(m_digits) : longint'(m_digits);
        m_digits = 0;
        m_neg    = 1'b0;
        r.loaded = 1'b1;
      end
    end else begin
      delta = m_accel * longint'(dt);
      if (delta > 0 && m_vel > VEL_MAX - delta) m_vel = VEL_MAX;
      else if (delta < 0 && m_vel < -VEL_MAX - delta) m_vel = -VEL_MAX;
      else m_vel = m_vel + delta;

      t = m_since + 64'(dt);
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      m_since = t;

      mag = (m_vel < 0) ? -m_vel : m_vel;
      if (mag > r_min && mag != 0 && m_since > (r_period * TEN_POW_8) / mag) begin
        m_since = 0;
        seq     = HALF_STEP_SEQ >> {m_pos[2:0], 2'b00};
        m_coils = seq[COIL_W-1:0];
        m_pos   = (m_vel > 0) ? m_pos + 1 : m_pos - 1;
        r.step  = 1'b1;
      end

      if (m_since > r_hold) m_coils = '0;
    end
    r.coils = m_coils;
    r.pos   = m_pos;
    r.vel   = m_vel[VEL_W-1:0];
    r.acc   = m_accel[ACCEL_W-1:0];
    return r;
  endfunction

  function automatic void add_row(input logic kind, input logic [CHAR_W-1:0] ch,
                                  input logic [DT_W-1:0] dt, input logic typed,
                                  input logic [ACCEL_W-1:0] acc, input logic loaded);
    dir_row_t row;
    row.kind   = kind;
    row.ch     = ch;
    row.dt     = dt;
    row.typed  = typed;
    row.acc    = acc;
    row.loaded = loaded;
    dir_tab.push_back(row);
  endfunction

  task automatic send_item(input logic kind, input logic [CHAR_W-1:0] ch,
                           input logic [DT_W-1:0] dt, input logic use_typed,
                           input drive_result_t typed_res);
    int            gap;
    drive_result_t want;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {dt, ch};
    do @(posedge clk); while (!in_tready);
    want = advance_driver(kind, ch, dt);
    result_q.push_back(use_typed ? typed_res : want);
    if (kind == KIND_TICK || ch == CHAR_MINUS || ch == CHAR_CR || ch == CHAR_LF ||
        (ch >= CHAR_ZERO && ch <= CHAR_NINE))
      items_sent++;
  endtask

  task automatic send_tick(input logic [DT_W-1:0] dt);
    send_item(KIND_TICK, CHAR_W'($urandom_range(0, 255)), dt, 1'b0, '0);
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] ch);
    send_item(KIND_CHAR, ch, DT_W'($urandom_range(0, 65535)), 1'b0, '0);
  endtask

  task automatic send_ticks(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 7) send_tick(DT_W'($urandom_range(0, 3000)));
      else if (r < 9) send_tick(DT_W'($urandom_range(0, 65535)));
      else send_tick($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
    end
  endtask

  // optional minus, digits, line end; now and then noise or a minus mid-number
  task automatic send_command();
    int n_dig;
    bit neg;
    bit late_minus;
    n_dig      = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 4);
    neg        = 1'($urandom_range(0, 1));
    late_minus = ($urandom_range(0, 5) == 0);
    if (neg && !late_minus) send_char(CHAR_MINUS);
    for (int i = 0; i < n_dig; i++) begin
      if ($urandom_range(0, 9) == 0) send_char(CHAR_W'($urandom_range(0, 255)));
      send_char(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
      if (neg && late_minus && i == n_dig / 2) send_char(CHAR_MINUS);
    end
    send_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input longint unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    case (idx)
      CFG_HOLD_TIMEOUT: r_hold   = val & 64'hFF_FFFF;
      CFG_MIN_SPEED:    r_min    = val & 64'hFF_FFFF_FFFF;
      CFG_PERIOD_UNIT:  r_period = val & 64'hFFFF;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input longint unsigned hold, input longint unsigned spd,
                                input longint unsigned period);
    write_reg(CFG_HOLD_TIMEOUT, hold);
    write_reg(CFG_MIN_SPEED, spd);
    write_reg(CFG_PERIOD_UNIT, period);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // stop sending and let every outstanding result come back
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  initial begin : result_sink
    int pct;
    int mode_left;
    out_tready = 1'b0;
    pct        = 100;
    mode_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (mode_left == 0) begin
        case ($urandom_range(0, 3))
          0:       pct = 100;
          1:       pct = 75;
          2:       pct = 40;
          default: pct = 10;
        endcase
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      out_tready <= ($urandom_range(0, 99) < pct);
    end
  end

  always @(posedge clk) begin : result_check
    drive_result_t got;
    drive_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.coils  = out_tdata[COIL_W-1:0];
      got.pos    = out_tdata[POS_LSB +: POS_W];
      got.vel    = out_tdata[VEL_LSB +: VEL_W];
      got.acc    = out_tdata[ACC_LSB +: ACCEL_W];
      got.step   = out_tuser[0];
      got.loaded = out_tuser[1];
      if (result_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected item: coils %h pos %h vel %h acc %h step %b loaded %b",
                   got.coils, got.pos, got.vel, got.acc, got.step, got.loaded);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch exp: coils %h pos %h vel %h acc %h step %b loaded %b",
                     want.coils, want.pos, want.vel, want.acc, want.step, want.loaded);
            $display("         got: coils %h pos %h vel %h acc %h step %b loaded %b",
                     got.coils, got.pos, got.vel, got.acc, got.step, got.loaded);
          end
        end
      end
    end
  end

  initial begin : stimulus
    drive_result_t typed_res;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    rst_n        = 1'b0;
    err_cnt      = 0;
    items_sent   = 0;
    burst_left   = 0;
    hold_off_req = 1'b0;

    m_vel    = 0;
    m_accel  = 0;
    m_digits = 0;
    m_neg    = 1'b0;
    m_pos    = '0;
    m_since  = 0;
    m_coils  = '0;
    r_hold   = 64'(HOLD_RESET);
    r_min    = 64'(MIN_SPEED_RESET);
    r_period = 64'(PERIOD_RESET);

    // typed rows expect a motor at rest: only acceleration and loaded vary
    add_row(KIND_TICK, 8'h00, 16'h0000, 1'b1, '0, 1'b0);
    add_row(KIND_TICK, 8'hFF, 16'hFFFF, 1'b1, '0, 1'b0);
    add_row(KIND_CHAR, 8'h41, 16'h0000, 1'b1, '0, 1'b0);
    add_row(KIND_CHAR, 8'hFF, 16'hFFFF, 1'b1, '0, 1'b0);
    add_row(KIND_CHAR, 8'h00, 16'h1234, 1'b1, '0, 1'b0);
    add_row(KIND_CHAR, CHAR_CR, 16'h0000, 1'b1, '0, 1'b1);
    // digit buffer overflow, then a minus after the digits
    repeat (8) add_row(KIND_CHAR, CHAR_NINE, 16'h0000, 1'b0, '0, 1'b0);
    add_row(KIND_CHAR, CHAR_MINUS, 16'h0000, 1'b0, '0, 1'b0);
    add_row(KIND_CHAR, CHAR_LF, 16'h0000, 1'b1, -25'sd16777215, 1'b1);
    add_row(KIND_TICK, 8'h00, 16'hFFFF, 1'b0, '0, 1'b0);
    add_row(KIND_TICK, 8'h00, 16'h0001, 1'b0, '0, 1'b0);
    add_row(KIND_CHAR, CHAR_ZERO + 8'd1, 16'h0000, 1'b0, '0, 1'b0);
    add_row(KIND_CHAR, CHAR_ZERO + 8'd2, 16'h0000, 1'b0, '0, 1'b0);
    add_row(KIND_CHAR, CHAR_LF, 16'h0000, 1'b0, '0, 1'b0);
    // minus with no digits loads zero
    add_row(KIND_CHAR, CHAR_MINUS, 16'h0000, 1'b0, '0, 1'b0);
    add_row(KIND_CHAR, CHAR_CR, 16'h0000, 1'b0, '0, 1'b0);
    add_row(KIND_TICK, 8'h55, 16'h5555, 1'b0, '0, 1'b0);
    add_row(KIND_TICK, 8'hAA, 16'hAAAA, 1'b0, '0, 1'b0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      typed_res        = '0;
      typed_res.acc    = dir_tab[i].acc;
      typed_res.loaded = dir_tab[i].loaded;
      send_item(dir_tab[i].kind, dir_tab[i].ch, dir_tab[i].dt, dir_tab[i].typed, typed_res);
    end
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: apply_settings(0, 0, 1);
        2: apply_settings(64'hFF_FFFF, 64'hFF_FFFF_FFFF, 64'hFFFF);
        3: apply_settings(64'($urandom_range(0, 200000)),
                          64'($urandom_range(0, 50000000)), 0);
        4: apply_settings(64'($urandom_range(0, 24'hFFFFFF)),
                          64'($urandom_range(0, 100000000)),
                          64'($urandom_range(1, 65535)));
        5: apply_settings(64'(HOLD_RESET), 64'(MIN_SPEED_RESET),
                          64'($urandom_range(200, 5000)));
        default: ;
      endcase

      if (p == 0) begin
        // result side holds off while the input keeps coming
        hold_off_req = 1'b1;
        burst_left   = 40;
        send_ticks(30);
      end

      if (p == 2) begin
        // full acceleration both ways until the velocity clips
        repeat (8) send_char(CHAR_NINE);
        send_char(CHAR_LF);
        repeat (SAT_TICKS_UP) send_tick(DT_W'($urandom_range(65000, 65535)));
        send_char(CHAR_MINUS);
        repeat (8) send_char(CHAR_NINE);
        send_char(CHAR_CR);
        repeat (SAT_TICKS_DOWN) send_tick(DT_W'($urandom_range(65000, 65535)));
      end

      begin : phase_body
        int target;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target) begin
          if ($urandom_range(0, 3) == 0) send_command();
          else send_ticks($urandom_range(1, 15));
        end
      end
      settle();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
